// ===== rtl/nps_pkg.sv =====
// Shared types and codes for the nonpreemptive priority scheduler.
// Used by nps_cmp, nps_store and nonpreemptive_priority_scheduler_core.
package nps_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;

    // Input word function codes.
    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // Result kind codes.
    localparam logic [2:0] KIND_ADD_OK   = 3'd0;
    localparam logic [2:0] KIND_ADD_DROP = 3'd1;
    localparam logic [2:0] KIND_IDLE     = 3'd2;
    localparam logic [2:0] KIND_RAN      = 3'd3;
    localparam logic [2:0] KIND_DONE     = 3'd4;

    // One entry of the ready store.
    typedef struct packed {
        logic [7:0]  ident;
        logic [7:0]  prio;
        logic [15:0] work;
        logic [31:0] arrival;
        logic [15:0] order;
    } t_entry;

    // Candidate entry presented to the compare unit.
    typedef struct packed {
        logic        valid;
        logic [7:0]  prio;
        logic [15:0] order;
    } t_cand;

    // Best entry found so far in a scan.
    typedef struct packed {
        logic        have;
        logic [7:0]  prio;
        logic [15:0] age;
    } t_best;

endpackage

// ===== rtl/nonpreemptive_priority_scheduler_core.sv =====
// Nonpreemptive priority scheduler. A word is taken when start is high and busy is low;
// each word gives exactly one result, shown for one cycle with o_strobe, which the
// receiver cannot stall. An add scans the valid bits one slot per cycle for the lowest
// free slot, and strobes when it writes one or finds the last slot taken. A tick
// with a job already running goes straight to its run step; a tick that must pick a
// job walks the ready store through its single read port and the shared compare unit,
// one entry per cycle, then runs the chosen job, or is reported idle when the store
// is empty. busy falls in the strobe cycle, so the next word may be taken then.
// Depends on nps_pkg, nps_cmp and nps_store.
module nonpreemptive_priority_scheduler_core #(
    parameter int QUEUE_DEPTH = nps_pkg::QUEUE_DEPTH_DEF,
    parameter int TIME_BITS   = nps_pkg::TIME_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_func,
    input  logic [7:0]         i_job_id,
    input  logic [15:0]        i_burst,
    input  logic [7:0]         i_priority_req,
    input  logic [31:0]        i_arrival_time,
    output logic               o_strobe,
    output logic [2:0]         o_kind,
    output logic [7:0]         o_job_id_res,
    output logic [31:0]        o_start_time,
    output logic [31:0]        o_finish_time,
    output logic signed [32:0] o_response_time,
    output logic [31:0]        o_time_now
);
    import nps_pkg::*;

    localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(QUEUE_DEPTH - 1);
    localparam int XW = (TIME_BITS > 33) ? TIME_BITS : 33;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ADD  = 2'd1;
    localparam logic [1:0] S_PICK = 2'd2;
    localparam logic [1:0] S_RUN  = 2'd3;

    logic [1:0]             r_state, n_state;
    logic [IW-1:0]          r_idx, n_idx;
    logic                   r_issue, n_issue;
    logic                   r_cmp_go, n_cmp_go;
    logic                   r_cmp_last, n_cmp_last;
    logic                   r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]          r_cmp_idx, n_cmp_idx;
    logic                   r_have, n_have;
    logic [IW-1:0]          r_best_idx, n_best_idx;
    t_entry                 r_best, n_best;
    logic [15:0]            r_best_age, n_best_age;
    logic [QUEUE_DEPTH-1:0] r_valid, n_valid;
    logic [15:0]            r_seq, n_seq;
    logic                   r_run_valid, n_run_valid;
    logic [7:0]             r_run_id, n_run_id;
    logic [15:0]            r_run_left, n_run_left;
    logic [31:0]            r_run_arr, n_run_arr;
    logic [TIME_BITS-1:0]   r_run_start, n_run_start;
    logic [TIME_BITS-1:0]   r_clock, n_clock;
    logic [TIME_BITS-1:0]   r_now, n_now;
    logic [7:0]             r_in_id, n_in_id;
    logic [15:0]            r_in_burst, n_in_burst;
    logic [7:0]             r_in_prio, n_in_prio;
    logic [31:0]            r_in_arr, n_in_arr;
    logic                   r_strobe, n_strobe;
    logic [2:0]             r_kind, n_kind;
    logic [7:0]             r_jid, n_jid;
    logic [31:0]            r_st, n_st;
    logic [31:0]            r_fin, n_fin;
    logic [32:0]            r_resp, n_resp;
    logic [31:0]            r_tnow, n_tnow;

    logic        mem_we;
    t_entry      mem_wdata;
    t_entry      mem_rdata;
    t_cand       cmp_cand;
    t_best       cmp_best;
    logic [15:0] cmp_age;
    logic        cmp_better;
    logic [XW-1:0] now_x;
    logic [XW-1:0] clk_x;
    logic [XW-1:0] start_x;
    logic [32:0]   resp_calc;

    nps_store #(
        .DEPTH (QUEUE_DEPTH),
        .IW    (IW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (r_idx),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    assign cmp_cand = '{valid: r_cmp_vld, prio: mem_rdata.prio, order: mem_rdata.order};
    assign cmp_best = '{have: r_have, prio: r_best.prio, age: r_best_age};

    nps_cmp u_cmp (
        .i_seq    (r_seq),
        .i_cand   (cmp_cand),
        .i_best   (cmp_best),
        .o_age    (cmp_age),
        .o_better (cmp_better)
    );

    assign mem_wdata = '{ident: r_in_id, prio: r_in_prio, work: r_in_burst,
                         arrival: r_in_arr, order: r_seq};

    assign now_x     = XW'(r_now);
    assign clk_x     = XW'(r_clock);
    assign start_x   = XW'(r_run_start);
    assign resp_calc = start_x[32:0] - {1'b0, r_run_arr};

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_issue     = r_issue;
        n_cmp_go    = 1'b0;
        n_cmp_last  = r_cmp_last;
        n_cmp_vld   = r_cmp_vld;
        n_cmp_idx   = r_cmp_idx;
        n_have      = r_have;
        n_best_idx  = r_best_idx;
        n_best      = r_best;
        n_best_age  = r_best_age;
        n_valid     = r_valid;
        n_seq       = r_seq;
        n_run_valid = r_run_valid;
        n_run_id    = r_run_id;
        n_run_left  = r_run_left;
        n_run_arr   = r_run_arr;
        n_run_start = r_run_start;
        n_clock     = r_clock;
        n_now       = r_now;
        n_in_id     = r_in_id;
        n_in_burst  = r_in_burst;
        n_in_prio   = r_in_prio;
        n_in_arr    = r_in_arr;
        n_strobe    = 1'b0;
        n_kind      = r_kind;
        n_jid       = r_jid;
        n_st        = r_st;
        n_fin       = r_fin;
        n_resp      = r_resp;
        n_tnow      = r_tnow;
        mem_we      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_in_id    = i_job_id;
                    n_in_burst = i_burst;
                    n_in_prio  = i_priority_req;
                    n_in_arr   = i_arrival_time;
                    n_now      = r_clock;
                    n_idx      = '0;
                    if (i_func == FUNC_ADD) begin
                        n_state = S_ADD;
                    end else begin
                        n_clock = r_clock + 1'b1;
                        if (r_run_valid) begin
                            n_state = S_RUN;
                        end else begin
                            n_state = S_PICK;
                            n_issue = 1'b1;
                            n_have  = 1'b0;
                        end
                    end
                end
            end
            S_ADD: begin
                n_jid  = r_in_id;
                n_st   = '0;
                n_fin  = '0;
                n_resp = '0;
                n_tnow = now_x[31:0];
                if (!r_valid[r_idx]) begin
                    mem_we         = 1'b1;
                    n_valid[r_idx] = 1'b1;
                    n_seq          = r_seq + 1'b1;
                    n_strobe       = 1'b1;
                    n_kind         = KIND_ADD_OK;
                    n_state        = S_IDLE;
                end else if (r_idx == LAST_IDX) begin
                    n_strobe = 1'b1;
                    n_kind   = KIND_ADD_DROP;
                    n_state  = S_IDLE;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_PICK: begin
                // The read issued for one slot is compared in the following cycle.
                n_cmp_go   = r_issue;
                n_cmp_idx  = r_idx;
                n_cmp_vld  = r_valid[r_idx];
                n_cmp_last = (r_idx == LAST_IDX);
                if (r_issue) begin
                    if (r_idx == LAST_IDX) begin
                        n_issue = 1'b0;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
                if (r_cmp_go && cmp_better) begin
                    n_have     = 1'b1;
                    n_best     = mem_rdata;
                    n_best_age = cmp_age;
                    n_best_idx = r_cmp_idx;
                end
                if (r_cmp_go && r_cmp_last) begin
                    if (!n_have) begin
                        n_strobe = 1'b1;
                        n_kind   = KIND_IDLE;
                        n_jid    = '0;
                        n_st     = '0;
                        n_fin    = '0;
                        n_resp   = '0;
                        n_tnow   = now_x[31:0];
                        n_state  = S_IDLE;
                    end else begin
                        n_valid[n_best_idx] = 1'b0;
                        n_run_valid = 1'b1;
                        n_run_id    = n_best.ident;
                        n_run_left  = n_best.work;
                        n_run_arr   = n_best.arrival;
                        n_run_start = r_now;
                        n_state     = S_RUN;
                    end
                end
            end
            S_RUN: begin
                n_strobe = 1'b1;
                n_jid    = r_run_id;
                n_st     = start_x[31:0];
                n_resp   = resp_calc;
                n_tnow   = now_x[31:0];
                n_state  = S_IDLE;
                if (r_run_left > 16'd1) begin
                    n_run_left = r_run_left - 1'b1;
                    n_kind     = KIND_RAN;
                    n_fin      = '0;
                end else begin
                    // A zero burst also finishes after its single tick.
                    n_run_left  = '0;
                    n_run_valid = 1'b0;
                    n_kind      = KIND_DONE;
                    n_fin       = clk_x[31:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_issue     <= 1'b0;
            r_cmp_go    <= 1'b0;
            r_cmp_last  <= 1'b0;
            r_cmp_vld   <= 1'b0;
            r_have      <= 1'b0;
            r_valid     <= '0;
            r_seq       <= '0;
            r_run_valid <= 1'b0;
            r_run_id    <= '0;
            r_run_left  <= '0;
            r_run_arr   <= '0;
            r_run_start <= '0;
            r_clock     <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_issue     <= n_issue;
            r_cmp_go    <= n_cmp_go;
            r_cmp_last  <= n_cmp_last;
            r_cmp_vld   <= n_cmp_vld;
            r_have      <= n_have;
            r_valid     <= n_valid;
            r_seq       <= n_seq;
            r_run_valid <= n_run_valid;
            r_run_id    <= n_run_id;
            r_run_left  <= n_run_left;
            r_run_arr   <= n_run_arr;
            r_run_start <= n_run_start;
            r_clock     <= n_clock;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= n_cmp_idx;
        r_best_idx <= n_best_idx;
        r_best     <= n_best;
        r_best_age <= n_best_age;
        r_now      <= n_now;
        r_in_id    <= n_in_id;
        r_in_burst <= n_in_burst;
        r_in_prio  <= n_in_prio;
        r_in_arr   <= n_in_arr;
        r_kind     <= n_kind;
        r_jid      <= n_jid;
        r_st       <= n_st;
        r_fin      <= n_fin;
        r_resp     <= n_resp;
        r_tnow     <= n_tnow;
    end

    assign busy            = (r_state != S_IDLE);
    assign o_strobe        = r_strobe;
    assign o_kind          = r_kind;
    assign o_job_id_res    = r_jid;
    assign o_start_time    = r_st;
    assign o_finish_time   = r_fin;
    assign o_response_time = signed'(r_resp);
    assign o_time_now      = r_tnow;

`ifndef ASSERT_OFF
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(busy))
        else $error("result strobe without a word in progress");

    a_done_clears_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind == KIND_DONE)) |-> !r_run_valid)
        else $error("finished job still marked as running");

    a_idle_store_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind == KIND_IDLE)) |-> (r_valid == '0) && !r_run_valid)
        else $error("idle tick reported while work was pending");

    a_drop_store_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_kind == KIND_ADD_DROP)) |-> (&r_valid))
        else $error("add dropped while the ready store had a free slot");
`endif

endmodule

// ===== rtl/nps_cmp.sv =====
// Shared compare unit: decides whether a scanned ready entry beats the best so far.
// Depends on nps_pkg for the candidate and best structs.
module nps_cmp (
    input  logic [15:0]    i_seq,
    input  nps_pkg::t_cand i_cand,
    input  nps_pkg::t_best i_best,
    output logic [15:0]    o_age,
    output logic           o_better
);
    import nps_pkg::*;

    // Age is how many successful adds, this entry's own included, have been stored since it was stamped.
    assign o_age = i_seq - i_cand.order;

    assign o_better = i_cand.valid &&
                      (!i_best.have || (i_cand.prio < i_best.prio) ||
                       ((i_cand.prio == i_best.prio) && (o_age > i_best.age)));

endmodule

// ===== rtl/nps_store.sv =====
// Ready store memory: one write port and one registered read port.
// Depends on nps_pkg for the entry type.
module nps_store #(
    parameter int DEPTH = nps_pkg::QUEUE_DEPTH_DEF,
    parameter int IW    = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [IW-1:0]   i_waddr,
    input  nps_pkg::t_entry i_wdata,
    input  logic [IW-1:0]   i_raddr,
    output nps_pkg::t_entry o_rdata
);
    import nps_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
